// ----- hdl/ttpf_pkg.sv -----
// ============================================================================
// ttpf_pkg: shared types and constants of the three-point parabola fit
// Item and result structs, status codes and the internal word widths.
// ============================================================================
package ttpf_pkg;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FIRST_SHORT  = 2'd1,
        ST_SECOND_SHORT = 2'd2,
        ST_REVERSED     = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] e_x;
        logic signed [31:0] e_y;
        logic signed [31:0] e_z;
        logic               action;
    } item_t;

    typedef struct packed {
        logic signed [47:0] k0_x;
        logic signed [47:0] k1_x;
        logic signed [47:0] k2_x;
        logic signed [47:0] k0_y;
        logic signed [47:0] k1_y;
        logic signed [47:0] k2_y;
        logic signed [47:0] k0_z;
        logic signed [47:0] k1_z;
        logic signed [47:0] k2_z;
        status_t            status;
    } result_t;

    // Register map (word index taken from paddr[2]).
    localparam logic REG_MIN_CHORD = 1'b0;
    localparam logic [15:0] MIN_CHORD_RST = 16'd66;

    localparam int MAG_W  = 32;               // magnitude of a coordinate difference
    localparam int RAD_W  = 66;               // sum of three squares
    localparam int LEN_W  = 34;               // chord length, Q18.16
    localparam int PROD_W = LEN_W + MAG_W;    // chord length times difference
    localparam int M_W    = PROD_W + 1;
    localparam int S_W    = LEN_W + 1;
    localparam int DEN_W  = 2 * LEN_W;
    localparam int NUM_W  = M_W + S_W;
    localparam int QUO_W  = 47;
    localparam int K_W    = 48;

    localparam int SQRT_LAT = LEN_W;
    localparam int DIV_LAT  = QUO_W + 2;
    localparam int K2_LAT   = DIV_LAT + 4;

    localparam logic signed [K_W-1:0] SAT_HI = {1'b0, {(K_W-1){1'b1}}};
    localparam logic signed [K_W-1:0] SAT_LO = {1'b1, {(K_W-1){1'b0}}};

endpackage

// ----- hdl/ttpf_delay.sv -----
// ============================================================================
// ttpf_delay: valid-tagged delay line
// Carries an item's side data alongside a fixed-latency datapath.
// ============================================================================
module ttpf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] data_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg[0] <= in_data;
        for (int i = 1; i < DEPTH; i++)
        begin
            data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

// ----- hdl/ttpf_isqrt.sv -----
// ============================================================================
// ttpf_isqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ============================================================================
module ttpf_isqrt (
    input  logic                       clk,
    input  logic [ttpf_pkg::RAD_W-1:0] rad,
    output logic [ttpf_pkg::LEN_W-1:0] root
);

    localparam int STEPS = ttpf_pkg::LEN_W;
    localparam int PAD_W = 2 * STEPS;
    localparam int REM_W = STEPS + 2;
    localparam int CUR_W = REM_W + 2;

    logic [STEPS-1:0] root_reg [STEPS];
    logic [REM_W-1:0] rem_reg  [STEPS];
    logic [PAD_W-1:0] rad_reg  [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [STEPS-1:0] root_in;
        logic [REM_W-1:0] rem_in;
        logic [PAD_W-1:0] rad_in;
        logic [CUR_W-1:0] cur;
        logic [CUR_W-1:0] trial;
        logic [CUR_W-1:0] diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = PAD_W'(rad);
        end
        else
        begin : g_rest
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // Bring down the next two radicand bits and try 4*root+1.
        assign cur   = {rem_in, rad_in[PAD_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge clk)
        begin
            root_reg[k] <= {root_in[STEPS-2:0], ge};
            rem_reg[k]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
            rad_reg[k]  <= {rad_in[PAD_W-3:0], 2'b00};
        end
    end

    assign root = root_reg[STEPS-1];

endmodule

// ----- hdl/ttpf_divide.sv -----
// ============================================================================
// ttpf_divide: pipelined saturating divider
// Signed quotient num/den truncated toward zero, one quotient bit per stage.
// ============================================================================
module ttpf_divide (
    input  logic                              clk,
    input  logic [ttpf_pkg::NUM_W-1:0]        num,
    input  logic [ttpf_pkg::DEN_W-1:0]        den,
    input  logic                              neg,
    output logic signed [ttpf_pkg::K_W-1:0]   quot
);

    localparam int NW    = ttpf_pkg::NUM_W;
    localparam int DW    = ttpf_pkg::DEN_W;
    localparam int QW    = ttpf_pkg::QUO_W;
    localparam int CMP_W = DW + QW;

    logic [NW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic          neg_reg [QW+1];
    logic          sat_reg [QW+1];
    logic signed [ttpf_pkg::K_W-1:0] quot_reg;
    logic signed [ttpf_pkg::K_W-1:0] quot_next;

    // A quotient of 2^47 or more cannot be represented and saturates.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        neg_reg[0] <= neg;
        sat_reg[0] <= (CMP_W'(num) >= (CMP_W'(den) << QW));
    end

    for (genvar j = 1; j <= QW; j++)
    begin : g_bit
        localparam int BIT = QW - j;
        logic [CMP_W-1:0] t;
        logic [CMP_W-1:0] rem_ext;
        logic [CMP_W-1:0] diff;
        logic             ge;

        assign t       = CMP_W'(den_reg[j-1]) << BIT;
        assign rem_ext = CMP_W'(rem_reg[j-1]);
        assign ge      = (rem_ext >= t);
        assign diff    = rem_ext - t;

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= ge ? diff[NW-1:0] : rem_reg[j-1];
            den_reg[j] <= den_reg[j-1];
            quo_reg[j] <= quo_reg[j-1] | (QW'(ge) << BIT);
            neg_reg[j] <= neg_reg[j-1];
            sat_reg[j] <= sat_reg[j-1];
        end
    end

    always_comb
    begin
        if (sat_reg[QW])
        begin
            quot_next = neg_reg[QW] ? ttpf_pkg::SAT_LO : ttpf_pkg::SAT_HI;
        end
        else if (neg_reg[QW])
        begin
            quot_next = -$signed({1'b0, quo_reg[QW]});
        end
        else
        begin
            quot_next = $signed({1'b0, quo_reg[QW]});
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

// ----- hdl/ttpf_k2.sv -----
// ============================================================================
// ttpf_k2: chord-mode quadratic coefficient of one axis
// k2 = (L1+L2)*(L1*dc - L2*db)/(L1*L2), truncated toward zero, saturated.
// ============================================================================
module ttpf_k2 (
    input  logic                             clk,
    input  logic [ttpf_pkg::LEN_W-1:0]       l1,
    input  logic [ttpf_pkg::LEN_W-1:0]       l2,
    input  logic signed [ttpf_pkg::MAG_W:0]  db,
    input  logic signed [ttpf_pkg::MAG_W:0]  dc,
    output logic signed [ttpf_pkg::K_W-1:0]  k2
);

    localparam int LW = ttpf_pkg::LEN_W;
    localparam int MW = ttpf_pkg::MAG_W;
    localparam int PW = ttpf_pkg::PROD_W;
    localparam int XW = ttpf_pkg::M_W;
    localparam int SW = ttpf_pkg::S_W;
    localparam int DW = ttpf_pkg::DEN_W;
    localparam int NW = ttpf_pkg::NUM_W;
    localparam int HI_W = XW - LW;

    logic [MW-1:0] mag_db;
    logic [MW-1:0] mag_dc;

    logic [PW-1:0] p_reg, q_reg;
    logic          np_reg, nq_reg;
    logic [SW-1:0] s1_reg, s2_reg;
    logic [DW-1:0] den1_reg, den2_reg, den3_reg, den4_reg;
    logic [XW-1:0] m_reg, m_next;
    logic          neg2_reg, neg3_reg, neg4_reg, neg_next;
    logic [LW+SW-1:0]   lo_reg;
    logic [HI_W+SW-1:0] hi_reg;
    logic [NW-1:0]      num_reg;

    assign mag_db = db[MW] ? MW'(-db) : db[MW-1:0];
    assign mag_dc = dc[MW] ? MW'(-dc) : dc[MW-1:0];

    always_ff @(posedge clk)
    begin
        p_reg    <= l1 * mag_dc;
        q_reg    <= l2 * mag_db;
        np_reg   <= dc[MW];
        nq_reg   <= !db[MW];
        s1_reg   <= SW'(l1) + SW'(l2);
        den1_reg <= l1 * l2;
    end

    // Signed difference L1*dc - L2*db held as sign and magnitude.
    always_comb
    begin
        if (np_reg == nq_reg)
        begin
            m_next   = XW'(p_reg) + XW'(q_reg);
            neg_next = np_reg;
        end
        else if (p_reg >= q_reg)
        begin
            m_next   = XW'(p_reg - q_reg);
            neg_next = np_reg;
        end
        else
        begin
            m_next   = XW'(q_reg - p_reg);
            neg_next = nq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        neg2_reg <= neg_next;
        s2_reg   <= s1_reg;
        den2_reg <= den1_reg;

        lo_reg   <= m_reg[LW-1:0] * s2_reg;
        hi_reg   <= m_reg[XW-1:LW] * s2_reg;
        neg3_reg <= neg2_reg;
        den3_reg <= den2_reg;

        num_reg  <= NW'({hi_reg, {LW{1'b0}}}) + NW'(lo_reg);
        neg4_reg <= neg3_reg;
        den4_reg <= den3_reg;
    end

    ttpf_divide u_divide (
        .clk  (clk),
        .num  (num_reg),
        .den  (den4_reg),
        .neg  (neg4_reg),
        .quot (k2)
    );

endmodule

// ----- hdl/three_point_parabola_fit.sv -----
// ============================================================================
// three_point_parabola_fit: parabola through three 3-D points
// Per-axis coefficients k0, k1, k2 of r(t) with r(0)=A, r(tb)=B, r(1)=E.
// ============================================================================
// Usage:
//   Input channel: drive item and raise start; the item is taken at the rising
//   edge where start is high and busy is low. busy stays low, so an item may
//   be offered in every cycle.
//   Output channel: each item gives one result, shown on result for a single
//   cycle with done high. The receiver must take it in that cycle.
//   Pipeline: the edge that takes the item registers the differences; then
//   come the squares, the sums, the chord square roots (one root bit per
//   stage), the status check, the k2 multiply and divide (one quotient bit
//   per stage), and the output register, which raises done. Throughput is
//   one item per cycle.
//   Configuration: min_chord is written over the APB port at address 0,
//   while no item is in flight. pready is always high.
//   Reset: clears every valid bit in flight and sets min_chord to 66.
// ============================================================================
module three_point_parabola_fit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ttpf_pkg::item_t     item,
    output logic                done,
    output ttpf_pkg::result_t   result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int MW = ttpf_pkg::MAG_W;
    localparam int LW = ttpf_pkg::LEN_W;
    localparam int RW = ttpf_pkg::RAD_W;
    localparam int KW = ttpf_pkg::K_W;
    localparam int CW = 36;     // width of the midpoint-mode coefficients

    typedef struct packed {
        logic                  action;
        logic                  rev;
        logic [2:0][31:0]      a;
        logic [2:0][MW:0]      ea;
        logic [2:0][CW-1:0]    mk1;
        logic [2:0][CW-1:0]    mk2;
        logic [2:0][MW:0]      db;
        logic [2:0][MW:0]      dc;
    } ctx_t;

    typedef struct packed {
        ttpf_pkg::status_t st;
        ctx_t              c;
    } tail_t;

    // ---------------- configuration ----------------
    logic [15:0] min_chord_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_chord_reg <= ttpf_pkg::MIN_CHORD_RST;
        end
        else if (psel && penable && pwrite && paddr[2] == ttpf_pkg::REG_MIN_CHORD)
        begin
            min_chord_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == ttpf_pkg::REG_MIN_CHORD) ? {16'd0, min_chord_reg} : '0;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // ---------------- stage 1: differences ----------------
    logic [2:0][31:0] pa, pb, pe;
    ctx_t             ctx1_next;
    logic [2:0][MW-1:0] mdb_next, mdc_next;
    logic [2:0]       sgn_next;

    assign pa = {item.a_z, item.a_y, item.a_x};
    assign pb = {item.b_z, item.b_y, item.b_x};
    assign pe = {item.e_z, item.e_y, item.e_x};

    always_comb
    begin
        ctx1_next        = '0;
        ctx1_next.action = item.action;
        for (int i = 0; i < 3; i++)
        begin
            logic [CW-1:0] a36, b36, e36;
            a36 = {{(CW-32){pa[i][31]}}, pa[i]};
            b36 = {{(CW-32){pb[i][31]}}, pb[i]};
            e36 = {{(CW-32){pe[i][31]}}, pe[i]};
            ctx1_next.a[i]   = pa[i];
            ctx1_next.db[i]  = {pb[i][31], pb[i]} - {pa[i][31], pa[i]};
            ctx1_next.dc[i]  = {pe[i][31], pe[i]} - {pb[i][31], pb[i]};
            ctx1_next.ea[i]  = {pe[i][31], pe[i]} - {pa[i][31], pa[i]};
            ctx1_next.mk1[i] = (b36 << 2) - (a36 * CW'(3)) - e36;
            ctx1_next.mk2[i] = (a36 << 1) - (b36 << 2) + (e36 << 1);
            mdb_next[i] = ctx1_next.db[i][MW] ? MW'(-ctx1_next.db[i])
                                              : ctx1_next.db[i][MW-1:0];
            mdc_next[i] = ctx1_next.dc[i][MW] ? MW'(-ctx1_next.dc[i])
                                              : ctx1_next.dc[i][MW-1:0];
            sgn_next[i] = ctx1_next.db[i][MW] ^ ctx1_next.dc[i][MW];
        end
    end

    ctx_t               ctx1_reg, ctx2_reg, ctx3_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic [2:0][MW-1:0] mdb_reg, mdc_reg;
    logic [2:0]         sgn1_reg, sgn2_reg;
    logic [2:0][2*MW-1:0] sq1_reg, sq2_reg, pr_reg;
    logic [RW-1:0]      s1_reg, s2_reg, pos_reg, negs_reg;
    logic [RW-1:0]      s1_next, s2_next, pos_next, negs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // ---------------- stages 2 and 3: squares, dot product, sums ----------------
    always_comb
    begin
        s1_next   = '0;
        s2_next   = '0;
        pos_next  = '0;
        negs_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            s1_next = s1_next + RW'(sq1_reg[i]);
            s2_next = s2_next + RW'(sq2_reg[i]);
            if (sgn2_reg[i])
            begin
                negs_next = negs_next + RW'(pr_reg[i]);
            end
            else
            begin
                pos_next = pos_next + RW'(pr_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx1_reg <= ctx1_next;
        mdb_reg  <= mdb_next;
        mdc_reg  <= mdc_next;
        sgn1_reg <= sgn_next;

        ctx2_reg <= ctx1_reg;
        sgn2_reg <= sgn1_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq1_reg[i] <= mdb_reg[i] * mdb_reg[i];
            sq2_reg[i] <= mdc_reg[i] * mdc_reg[i];
            pr_reg[i]  <= mdb_reg[i] * mdc_reg[i];
        end

        ctx3_reg <= ctx2_reg;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        pos_reg  <= pos_next;
        negs_reg <= negs_next;
    end

    // ---------------- chord lengths ----------------
    ctx_t          ctx_sq_in, ctx_sq_out;
    logic          v_sq_out;
    logic [LW-1:0] l1, l2;

    always_comb
    begin
        ctx_sq_in     = ctx3_reg;
        ctx_sq_in.rev = (negs_reg > pos_reg);
    end

    ttpf_isqrt u_sqrt_first (
        .clk  (clk),
        .rad  (s1_reg),
        .root (l1)
    );

    ttpf_isqrt u_sqrt_second (
        .clk  (clk),
        .rad  (s2_reg),
        .root (l2)
    );

    ttpf_delay #(
        .WIDTH ($bits(ctx_t)),
        .DEPTH (ttpf_pkg::SQRT_LAT)
    ) u_delay_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_data   (ctx_sq_in),
        .out_valid (v_sq_out),
        .out_data  (ctx_sq_out)
    );

    // ---------------- status ----------------
    ttpf_pkg::status_t st_next, stp_reg;
    ctx_t              ctxp_reg;
    logic              vp_reg;
    logic [LW-1:0]     l1p_reg, l2p_reg;

    always_comb
    begin
        priority if (l1 == '0 || l1 < LW'(min_chord_reg))
        begin
            st_next = ttpf_pkg::ST_FIRST_SHORT;
        end
        else if (l2 == '0 || l2 < LW'(min_chord_reg))
        begin
            st_next = ttpf_pkg::ST_SECOND_SHORT;
        end
        else if (ctx_sq_out.rev)
        begin
            st_next = ttpf_pkg::ST_REVERSED;
        end
        else
        begin
            st_next = ttpf_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
        end
        else
        begin
            vp_reg <= v_sq_out;
        end
    end

    always_ff @(posedge clk)
    begin
        stp_reg  <= st_next;
        ctxp_reg <= ctx_sq_out;
        l1p_reg  <= l1;
        l2p_reg  <= l2;
    end

    // ---------------- chord-mode k2 per axis ----------------
    logic [2:0][KW-1:0] k2c;

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        ttpf_k2 u_k2 (
            .clk (clk),
            .l1  (l1p_reg),
            .l2  (l2p_reg),
            .db  ($signed(ctxp_reg.db[i])),
            .dc  ($signed(ctxp_reg.dc[i])),
            .k2  (k2c[i])
        );
    end

    tail_t tail_in, tail_out;
    logic  v_tail;

    assign tail_in.st = stp_reg;
    assign tail_in.c  = ctxp_reg;

    ttpf_delay #(
        .WIDTH ($bits(tail_t)),
        .DEPTH (ttpf_pkg::K2_LAT)
    ) u_delay_k2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vp_reg),
        .in_data   (tail_in),
        .out_valid (v_tail),
        .out_data  (tail_out)
    );

    // ---------------- output ----------------
    logic [2:0][KW-1:0] k0_next, k1_next, k2_next;
    ttpf_pkg::result_t  result_reg, result_next;
    logic               done_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [KW:0] diff;
            diff = {{(KW-MW){tail_out.c.ea[i][MW]}}, tail_out.c.ea[i]}
                   - {k2c[i][KW-1], k2c[i]};
            if (tail_out.st != ttpf_pkg::ST_OK)
            begin
                k0_next[i] = '0;
                k1_next[i] = '0;
                k2_next[i] = '0;
            end
            else if (tail_out.c.action)
            begin
                k0_next[i] = {{(KW-32){tail_out.c.a[i][31]}}, tail_out.c.a[i]};
                k1_next[i] = {{(KW-CW){tail_out.c.mk1[i][CW-1]}}, tail_out.c.mk1[i]};
                k2_next[i] = {{(KW-CW){tail_out.c.mk2[i][CW-1]}}, tail_out.c.mk2[i]};
            end
            else
            begin
                k0_next[i] = {{(KW-32){tail_out.c.a[i][31]}}, tail_out.c.a[i]};
                k2_next[i] = k2c[i];
                if (diff[KW] != diff[KW-1])
                begin
                    k1_next[i] = diff[KW] ? ttpf_pkg::SAT_LO : ttpf_pkg::SAT_HI;
                end
                else
                begin
                    k1_next[i] = diff[KW-1:0];
                end
            end
        end
        result_next.k0_x   = k0_next[0];
        result_next.k1_x   = k1_next[0];
        result_next.k2_x   = k2_next[0];
        result_next.k0_y   = k0_next[1];
        result_next.k1_y   = k1_next[1];
        result_next.k2_y   = k2_next[1];
        result_next.k0_z   = k0_next[2];
        result_next.k1_z   = k1_next[2];
        result_next.k2_z   = k2_next[2];
        result_next.status = tail_out.st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v_tail;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions ----------------
    logic coef_zero;

    assign coef_zero = (result.k0_x == '0) && (result.k1_x == '0) && (result.k2_x == '0)
                    && (result.k0_y == '0) && (result.k1_y == '0) && (result.k2_y == '0)
                    && (result.k0_z == '0) && (result.k1_z == '0) && (result.k2_z == '0);

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ttpf_pkg::ST_OK |-> coef_zero)
        else $error("error result carries nonzero coefficients");

    a_status_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg && stp_reg == ttpf_pkg::ST_OK |->
            l1p_reg != '0 && l2p_reg != '0
            && l1p_reg >= LW'(min_chord_reg) && l2p_reg >= LW'(min_chord_reg))
        else $error("status ok with a short chord");

    a_tail_done: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg |-> !$isunknown(stp_reg))
        else $error("status unknown for an item in flight");

endmodule
